FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define OSE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define OSE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ose_pkg.sv
// Package with the types and constants of the operand stack engine.
`timescale 1ns / 1ps

package ose_pkg;

   localparam int DefaultStackDepth = 256;
   localparam int DataWidth         = 32;
   localparam int PosWidth          = 9;
   localparam int KindWidth         = 3;
   localparam int StatusWidth       = 2;
   localparam int PairWidth         = PosWidth - 1;
   localparam int ReqDataWidth      = 48;
   localparam int RspDataWidth      = 48;

   typedef enum logic [KindWidth-1:0] {
      KIND_PUSH    = 3'd0,
      KIND_PEEK    = 3'd1,
      KIND_POP_N   = 3'd2,
      KIND_POP_TOP = 3'd3,
      KIND_REPLACE = 3'd4,
      KIND_REVERSE = 3'd5,
      KIND_SWAP    = 3'd6,
      KIND_CLEAR   = 3'd7
   } kind_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RD_WAIT,
      S_RD_HI,
      S_WR_LO,
      S_WR_HI,
      S_HOLD
   } state_type;

   // One finished result word as handed from the sequencer to the output register.
   typedef struct packed {
      logic [DataWidth-1:0] data;
      logic [PosWidth-1:0]  depth;
      status_type           status;
   } result_type;

endpackage

FILE: hw/rtl/ose_mem.sv
// Entry store of the stack: one write port and one registered read port.
`timescale 1ns / 1ps

module ose_mem
   import ose_pkg::*;
#(
   parameter int Depth = DefaultStackDepth
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [$clog2(Depth)-1:0]   rd_addr,
   output logic [DataWidth-1:0]       rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(Depth)-1:0]   wr_addr,
   input  logic [DataWidth-1:0]       wr_data
);

   logic [DataWidth-1:0] mem_ff [Depth];
   logic [DataWidth-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/ose_outreg.sv
// Output register of the result channel.
`timescale 1ns / 1ps

module ose_outreg
   import ose_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  result_type              res,
   output logic                    free,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   // The register can take a word when empty or when its word leaves now.
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RspDataWidth'({res_ff.status, res_ff.depth, res_ff.data});

endmodule

FILE: hw/rtl/ose_ctrl.sv
// Sequencer of the stack: decodes a word, drives the entry store and builds the result.
`timescale 1ns / 1ps

module ose_ctrl
   import ose_pkg::*;
#(
   parameter int StackDepth = DefaultStackDepth
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  kind_type                        req_kind,
   input  logic [DataWidth-1:0]            req_value,
   input  logic [PosWidth-1:0]             req_position,
   output logic                            mem_rd_en,
   output logic [$clog2(StackDepth)-1:0]   mem_rd_addr,
   input  logic [DataWidth-1:0]            mem_rd_data,
   output logic                            mem_wr_en,
   output logic [$clog2(StackDepth)-1:0]   mem_wr_addr,
   output logic [DataWidth-1:0]            mem_wr_data,
   input  logic                            out_free,
   output logic                            fin_load,
   output result_type                      fin_res
);

   localparam int AW = $clog2(StackDepth);
   localparam int CW = $clog2(StackDepth + 1);
   localparam int XW = (CW > PosWidth) ? CW : PosWidth;

   state_type             state_ff, state_in;
   kind_type              kind_ff, kind_in;
   logic [DataWidth-1:0]  value_ff, value_in;
   logic [PosWidth-1:0]   pos_ff, pos_in;
   logic [CW-1:0]         held_ff, held_in;
   logic [AW-1:0]         lo_ff, lo_in;
   logic [AW-1:0]         hi_ff, hi_in;
   logic [PairWidth-1:0]  pairs_ff, pairs_in;
   logic [DataWidth-1:0]  tmp_ff, tmp_in;
   result_type            pend_ff, pend_in;

   logic [XW-1:0]         held_x;
   logic [XW-1:0]         pos_x;
   logic [AW-1:0]         top_idx;
   logic [AW-1:0]         depth_idx;
   logic [PairWidth-1:0]  pairs_start;
   status_type            exec_status;
   logic                  exec_ok;
   logic                  goes_read;
   logic                  goes_loop;
   logic                  done_now;
   result_type            res_now;

   // Range checks and addresses of the word in hand.
   always_comb begin
      held_x      = XW'(held_ff);
      pos_x       = XW'(pos_ff);
      top_idx     = AW'(held_ff - 1'b1);
      depth_idx   = AW'(held_x - pos_x - 1'b1);
      pairs_start = (kind_ff == KIND_SWAP) ? PairWidth'(1) : pos_ff[PosWidth-1:1];
      exec_status = ST_OK;
      case (kind_ff)
         KIND_PUSH: begin
            if (held_ff == CW'(StackDepth)) begin
               exec_status = ST_OVERFLOW;
            end
         end
         KIND_PEEK, KIND_REPLACE: begin
            if (pos_x >= held_x) begin
               exec_status = ST_RANGE;
            end
         end
         KIND_POP_N, KIND_REVERSE: begin
            if (pos_x > held_x) begin
               exec_status = ST_RANGE;
            end
         end
         KIND_POP_TOP: begin
            if (held_ff == '0) begin
               exec_status = ST_RANGE;
            end
         end
         KIND_SWAP: begin
            if (held_ff < CW'(2)) begin
               exec_status = ST_RANGE;
            end
         end
         default: begin
            exec_status = ST_OK;
         end
      endcase
      exec_ok   = (exec_status == ST_OK);
      goes_read = exec_ok && (kind_ff == KIND_PEEK || kind_ff == KIND_POP_TOP);
      goes_loop = exec_ok && (kind_ff == KIND_REVERSE || kind_ff == KIND_SWAP) &&
                  (pairs_start != '0);
      done_now  = (state_ff == S_EXEC && !goes_read && !goes_loop) ||
                  (state_ff == S_RD_WAIT) ||
                  (state_ff == S_WR_HI && pairs_ff <= PairWidth'(1));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (goes_read) begin
               state_in = S_RD_WAIT;
            end else if (goes_loop) begin
               state_in = S_RD_HI;
            end
         end
         S_RD_HI: begin
            state_in = S_WR_LO;
         end
         S_WR_LO: begin
            state_in = S_WR_HI;
         end
         S_WR_HI: begin
            state_in = S_WR_LO;
         end
         S_HOLD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // Every finishing state leaves through the same exit.
      if (done_now) begin
         state_in = out_free ? S_IDLE : S_HOLD;
      end
   end

   // Store accesses, register updates and the result word.
   always_comb begin
      req_tready  = (state_ff == S_IDLE);
      kind_in     = kind_ff;
      value_in    = value_ff;
      pos_in      = pos_ff;
      held_in     = held_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      pairs_in    = pairs_ff;
      tmp_in      = tmp_ff;
      pend_in     = pend_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = lo_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = lo_ff;
      mem_wr_data = mem_rd_data;
      fin_load    = 1'b0;
      fin_res     = pend_ff;
      res_now.data   = '0;
      res_now.status = ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_kind;
               value_in = req_value;
               pos_in   = req_position;
            end
         end
         S_EXEC: begin
            res_now.status = exec_status;
            if (exec_ok) begin
               case (kind_ff)
                  KIND_PUSH: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = AW'(held_ff);
                     mem_wr_data = value_ff;
                     held_in     = CW'(held_ff + 1'b1);
                  end
                  KIND_PEEK: begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = depth_idx;
                  end
                  KIND_POP_N: begin
                     held_in = CW'(held_x - pos_x);
                  end
                  KIND_POP_TOP: begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = top_idx;
                     held_in     = CW'(held_ff - 1'b1);
                  end
                  KIND_REPLACE: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = depth_idx;
                     mem_wr_data = value_ff;
                  end
                  KIND_REVERSE, KIND_SWAP: begin
                     // Set up the outermost pair and fetch its low entry.
                     lo_in       = AW'(held_x - XW'(pairs_start) - XW'(pairs_start)
                                       - XW'(pos_ff[0] & (kind_ff == KIND_REVERSE)));
                     hi_in       = top_idx;
                     pairs_in    = pairs_start;
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = lo_in;
                  end
                  KIND_CLEAR: begin
                     held_in = '0;
                  end
                  default: begin
                     held_in = '0;
                  end
               endcase
            end
         end
         S_RD_WAIT: begin
            res_now.data = mem_rd_data;
         end
         S_RD_HI: begin
            // Low entry arrives; fetch the high one.
            tmp_in      = mem_rd_data;
            mem_rd_en   = 1'b1;
            mem_rd_addr = hi_ff;
         end
         S_WR_LO: begin
            // High entry arrives and goes low; fetch the next low entry if another pair remains.
            mem_wr_en   = 1'b1;
            mem_wr_addr = lo_ff;
            mem_wr_data = mem_rd_data;
            if (pairs_ff > PairWidth'(1)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(lo_ff + 1'b1);
            end
         end
         S_WR_HI: begin
            // Saved low entry goes high; if another pair remains, the next low entry arrives.
            mem_wr_en   = 1'b1;
            mem_wr_addr = hi_ff;
            mem_wr_data = tmp_ff;
            pairs_in    = PairWidth'(pairs_ff - 1'b1);
            lo_in       = AW'(lo_ff + 1'b1);
            hi_in       = AW'(hi_ff - 1'b1);
            if (pairs_ff > PairWidth'(1)) begin
               tmp_in      = mem_rd_data;
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(hi_ff - 1'b1);
            end
         end
         S_HOLD: begin
            fin_load = out_free;
         end
         default: begin
            fin_load = 1'b0;
         end
      endcase

      res_now.depth = PosWidth'(held_in);
      if (done_now) begin
         if (out_free) begin
            fin_load = 1'b1;
            fin_res  = res_now;
         end else begin
            pend_in = res_now;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         held_ff  <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
      end
   end

   // Operands and loop registers.
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      pos_ff   <= pos_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      pairs_ff <= pairs_in;
      tmp_ff   <= tmp_in;
      pend_ff  <= pend_in;
   end

endmodule

FILE: hw/rtl/operand_stack_engine_core.sv
// Top level of the operand stack engine.
//
//   Port group  Direction  Words carried
//   req_        in         operation: tuser = kind, tdata = value, position
//   rsp_        out        result: tdata = data, depth, status
//
// Push, pop n, replace and clear finish in S_EXEC; peek and pop top
// then finish in S_RD_WAIT, as the read port of the entry store is registered.
// Reverse of n >= 2 entries and swap run through S_RD_HI, then through S_WR_LO and
// S_WR_HI once per pair, as the entry store has a single read and a single write port.
// A failed operation and a reverse of fewer than two entries finish in S_EXEC.
// Reset clears the held count and empties the output register; entries are not cleared.
// A finished result waits in the sequencer while the output register is stalled;
// a new word is accepted as soon as the sequencer has handed its result on.
`timescale 1ns / 1ps

module operand_stack_engine_core
   import ose_pkg::*;
#(
   parameter int STACK_DEPTH = DefaultStackDepth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,   // value[31:0], position[40:32], zero above
   input  logic [KindWidth-1:0]    req_tuser,   // kind[2:0]
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata    // data[31:0], depth[40:32], status[42:41], zero above
);

   localparam int AW = $clog2(STACK_DEPTH);

   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   logic [DataWidth-1:0] mem_rd_data;
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [DataWidth-1:0] mem_wr_data;
   logic                 out_free;
   logic                 fin_load;
   result_type           fin_res;

   ose_ctrl #(
      .StackDepth (STACK_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_kind     (kind_type'(req_tuser)),
      .req_value    (req_tdata[DataWidth-1:0]),
      .req_position (req_tdata[DataWidth+PosWidth-1:DataWidth]),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .out_free     (out_free),
      .fin_load     (fin_load),
      .fin_res      (fin_res)
   );

   ose_mem #(
      .Depth (STACK_DEPTH)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   ose_outreg u_outreg (
      .clock      (clock),
      .reset      (reset),
      .load       (fin_load),
      .res        (fin_res),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: hw/rtl/ose_checker.sv
// Port checker of the operand stack engine and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ose_checker
   import ose_pkg::*;
#(
   parameter int STACK_DEPTH = DefaultStackDepth
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata
);

   logic [DataWidth-1:0]   rsp_data;
   logic [PosWidth-1:0]    rsp_depth;
   logic [StatusWidth-1:0] rsp_status;

   assign rsp_data   = rsp_tdata[DataWidth-1:0];
   assign rsp_depth  = rsp_tdata[DataWidth+PosWidth-1:DataWidth];
   assign rsp_status = rsp_tdata[DataWidth+PosWidth+StatusWidth-1:DataWidth+PosWidth];

   // After reset the block is empty and ready for a word.
   `OSE_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_tvalid && req_tready), "not idle after reset")

   // A stalled result word stays put.
   `OSE_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "result word changed under stall")

   // Each operation passes through the execute state after acceptance, so no word is accepted back to back.
   `OSE_ASSERT(a_req_gap, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "words accepted back to back")

   // A failed operation returns no data and only known status codes appear.
   `OSE_ASSERT(a_err_data, clock, reset, rsp_tvalid |-> ((rsp_status == ST_OK) || ((rsp_status == ST_RANGE || rsp_status == ST_OVERFLOW) && rsp_data == '0)), "bad status or data on failure")

   // Overflow is reported only with the stack full.
   `OSE_ASSERT(a_ovf_full, clock, reset, (rsp_tvalid && rsp_status == ST_OVERFLOW) |-> (rsp_depth == PosWidth'(STACK_DEPTH)), "overflow below full depth")

endmodule

bind operand_stack_engine_core ose_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_checker (.*);
